// ===== sv/m68k_dec_pkg.sv =====
// Package with the types, codes and helper functions of the 68000/68010 opcode decoder.
package m68k_dec_pkg;

   // Input word: opcode and the extension word after it.
   typedef struct packed {
      logic [15:0] opcode_word;
      logic [15:0] first_extension;
   } req_type;

   // Decoded result word.
   typedef struct packed {
      logic        valid_res;
      logic [6:0]  mnemonic;
      logic [3:0]  condition;
      logic [1:0]  op_size;
      logic [4:0]  src_kind;
      logic [2:0]  src_register;
      logic [4:0]  dst_kind;
      logic [2:0]  dst_register;
      logic [2:0]  extension_count;
      logic [7:0]  quick_value;
      logic [15:0] register_mask;
   } rsp_type;

   // Operand sizes.
   localparam logic [1:0] SZ_N = 2'd0;
   localparam logic [1:0] SZ_B = 2'd1;
   localparam logic [1:0] SZ_W = 2'd2;
   localparam logic [1:0] SZ_L = 2'd3;

   // Operand kinds.
   localparam logic [4:0] K_NONE  = 5'd0;
   localparam logic [4:0] K_DN    = 5'd1;
   localparam logic [4:0] K_AN    = 5'd2;
   localparam logic [4:0] K_POST  = 5'd4;
   localparam logic [4:0] K_PRE   = 5'd5;
   localparam logic [4:0] K_D16   = 5'd6;
   localparam logic [4:0] K_ABSW  = 5'd8;
   localparam logic [4:0] K_ABSL  = 5'd9;
   localparam logic [4:0] K_PCD   = 5'd10;
   localparam logic [4:0] K_PCX   = 5'd11;
   localparam logic [4:0] K_IMM   = 5'd12;
   localparam logic [4:0] K_SR    = 5'd13;
   localparam logic [4:0] K_CCR   = 5'd14;
   localparam logic [4:0] K_USP   = 5'd15;
   localparam logic [4:0] K_CTRL  = 5'd16;
   localparam logic [4:0] K_LIST  = 5'd17;
   localparam logic [4:0] K_QUICK = 5'd18;
   localparam logic [4:0] K_DISP  = 5'd19;

   // Mnemonic codes.
   localparam logic [6:0] M_ORI = 7'd0, M_ANDI = 7'd1, M_SUBI = 7'd2, M_ADDI = 7'd3,
      M_EORI = 7'd4, M_CMPI = 7'd5, M_MOVES = 7'd6, M_BTST = 7'd7, M_BCHG = 7'd8,
      M_BCLR = 7'd9, M_BSET = 7'd10, M_MOVEP = 7'd11, M_MOVE = 7'd12, M_MOVEA = 7'd13,
      M_CHK = 7'd14, M_LEA = 7'd15, M_MOVEM = 7'd16, M_EXT = 7'd17, M_TAS = 7'd18,
      M_ILLEGAL = 7'd19, M_JMP = 7'd20, M_NEGX = 7'd21, M_CLR = 7'd22, M_NEG = 7'd23,
      M_NOT = 7'd24, M_NBCD = 7'd25, M_SWAP = 7'd26, M_PEA = 7'd27, M_TST = 7'd28,
      M_TRAP = 7'd29, M_LINK = 7'd30, M_UNLK = 7'd31, M_RESET = 7'd32, M_NOP = 7'd33,
      M_STOP = 7'd34, M_RTE = 7'd35, M_RTD = 7'd36, M_RTS = 7'd37, M_TRAPV = 7'd38,
      M_RTR = 7'd39, M_MOVEC = 7'd40, M_JSR = 7'd41, M_DBCC = 7'd42, M_SCC = 7'd43,
      M_ADDQ = 7'd44, M_SUBQ = 7'd45, M_BCC = 7'd46, M_MOVEQ = 7'd47, M_EXG = 7'd48,
      M_DIVU = 7'd49, M_DIVS = 7'd50, M_MULU = 7'd51, M_MULS = 7'd52, M_SBCD = 7'd53,
      M_ABCD = 7'd54, M_OR = 7'd55, M_AND = 7'd56, M_SUBA = 7'd57, M_ADDA = 7'd58,
      M_SUBX = 7'd59, M_ADDX = 7'd60, M_SUB = 7'd61, M_ADD = 7'd62, M_CMPA = 7'd63,
      M_CMPM = 7'd64, M_EOR = 7'd65, M_CMP = 7'd66, M_ASL = 7'd67, M_LSL = 7'd68,
      M_ROXL = 7'd69, M_ROL = 7'd70, M_ASR = 7'd71, M_LSR = 7'd72, M_ROXR = 7'd73,
      M_ROR = 7'd74;

   // Control register codes accepted by movec.
   localparam logic [11:0] CR_SFC = 12'h000;
   localparam logic [11:0] CR_DFC = 12'h001;
   localparam logic [11:0] CR_USP = 12'h800;
   localparam logic [11:0] CR_VBR = 12'h801;

   // Effective address decode: kind, extension words and a legality flag.
   typedef struct packed {
      logic       ok;
      logic [4:0] kind;
      logic [2:0] regn;
      logic [2:0] ext;
   } ea_type;

   // Size field in bits 7..6 of most opcodes.
   function automatic logic [1:0] size_of_bits(input logic [1:0] b);
      logic [1:0] s;
      unique case (b)
         2'd0: s = SZ_B;
         2'd1: s = SZ_W;
         2'd2: s = SZ_L;
         default: s = SZ_N;
      endcase
      return s;
   endfunction

   // Decode one mode/register pair.
   function automatic ea_type ea_dec(input logic [2:0] mode, input logic [2:0] rn,
                                     input logic [1:0] size);
      ea_type e;
      e = '{ok: 1'b1, kind: K_NONE, regn: 3'd0, ext: 3'd0};
      if (mode != 3'd7) begin
         e.kind = {2'b00, mode} + 5'd1;
         e.regn = rn;
         if (mode == 3'd5 || mode == 3'd6) e.ext = 3'd1;
      end else begin
         unique case (rn)
            3'd0: begin e.kind = K_ABSW; e.ext = 3'd1; end
            3'd1: begin e.kind = K_ABSL; e.ext = 3'd2; end
            3'd2: begin e.kind = K_PCD;  e.ext = 3'd1; end
            3'd3: begin e.kind = K_PCX;  e.ext = 3'd1; end
            3'd4: begin
               e.kind = K_IMM;
               e.ext  = (size == SZ_B || size == SZ_W) ? 3'd1 : 3'd2;
            end
            default: e.ok = 1'b0;
         endcase
      end
      return e;
   endfunction

endpackage

// ===== sv/m68k_dec_logic.sv =====
// Combinational opcode decode of one 68000/68010 instruction word.
module m68k_dec_logic (
   input  m68k_dec_pkg::req_type word_in,
   output m68k_dec_pkg::rsp_type word_out
);

   logic [15:0] op;
   logic [15:0] x;
   logic [3:0]  top;
   logic [1:0]  b76;
   logic [2:0]  sm, sr, dm, dr;
   logic        b8;
   logic [15:0] xrev;
   m68k_dec_pkg::rsp_type d;

   assign op  = word_in.opcode_word;
   assign x   = word_in.first_extension;
   assign top = op[15:12];
   assign b76 = op[7:6];
   assign sm  = op[5:3];
   assign sr  = op[2:0];
   assign dm  = op[8:6];
   assign dr  = op[11:9];
   assign b8  = op[8];

   // Bit-reversed extension word for the predecrement movem form.
   always_comb begin
      for (int i = 0; i < 16; i++) xrev[i] = x[15 - i];
   end

   // Main decode tree.
   always_comb begin
      m68k_dec_pkg::ea_type es, ed;
      logic ok;
      logic [1:0] sz;
      es = m68k_dec_pkg::ea_dec(sm, sr, m68k_dec_pkg::SZ_N);
      ed = es;
      ok = 1'b1;
      sz = m68k_dec_pkg::SZ_N;
      d  = '0;
      d.valid_res = 1'b1;
      unique case (top)
         4'h0: begin
            if (b8 || op[11:8] == 4'h8) begin
               if (sm == 3'd1) begin
                  d.mnemonic = m68k_dec_pkg::M_MOVEP;
                  d.op_size = op[6] ? m68k_dec_pkg::SZ_L : m68k_dec_pkg::SZ_W;
                  d.extension_count = 3'd1;
                  if (op[7]) begin
                     d.src_kind = m68k_dec_pkg::K_DN;  d.src_register = dr;
                     d.dst_kind = m68k_dec_pkg::K_D16; d.dst_register = sr;
                  end else begin
                     d.src_kind = m68k_dec_pkg::K_D16; d.src_register = sr;
                     d.dst_kind = m68k_dec_pkg::K_DN;  d.dst_register = dr;
                  end
               end else begin
                  d.mnemonic = m68k_dec_pkg::M_BTST + {5'd0, b76};
                  sz = (sm != 3'd0) ? m68k_dec_pkg::SZ_B : m68k_dec_pkg::SZ_L;
                  d.op_size = sz;
                  ed = m68k_dec_pkg::ea_dec(sm, sr, sz);
                  if (b8) begin
                     d.src_kind = m68k_dec_pkg::K_DN; d.src_register = dr;
                  end else begin
                     d.src_kind = m68k_dec_pkg::K_IMM;
                     d.extension_count = 3'd1;
                  end
                  ok = ed.ok;
                  d.dst_kind = ed.kind; d.dst_register = ed.regn;
                  d.extension_count = d.extension_count + ed.ext;
               end
            end else if (dr == 3'd7) begin
               d.mnemonic = m68k_dec_pkg::M_MOVES;
               sz = m68k_dec_pkg::size_of_bits(b76);
               d.op_size = sz;
               ed = m68k_dec_pkg::ea_dec(sm, sr, sz);
               ok = (sz != m68k_dec_pkg::SZ_N) && ed.ok;
               d.extension_count = 3'd1 + ed.ext;
               if (x[11]) begin
                  d.src_kind = x[15] ? m68k_dec_pkg::K_AN : m68k_dec_pkg::K_DN;
                  d.src_register = x[14:12];
                  d.dst_kind = ed.kind; d.dst_register = ed.regn;
               end else begin
                  d.src_kind = ed.kind; d.src_register = ed.regn;
                  d.dst_kind = x[15] ? m68k_dec_pkg::K_AN : m68k_dec_pkg::K_DN;
                  d.dst_register = x[14:12];
               end
            end else begin
               unique case (dr)
                  3'd0: d.mnemonic = m68k_dec_pkg::M_ORI;
                  3'd1: d.mnemonic = m68k_dec_pkg::M_ANDI;
                  3'd2: d.mnemonic = m68k_dec_pkg::M_SUBI;
                  3'd3: d.mnemonic = m68k_dec_pkg::M_ADDI;
                  3'd5: d.mnemonic = m68k_dec_pkg::M_EORI;
                  3'd6: d.mnemonic = m68k_dec_pkg::M_CMPI;
                  default: d.mnemonic = m68k_dec_pkg::M_ORI;
               endcase
               if (sm == 3'd7 && sr == 3'd4) begin
                  // Immediate to ccr or sr.
                  ok = (dr == 3'd0 || dr == 3'd1 || dr == 3'd5) && !op[7];
                  d.op_size = op[6] ? m68k_dec_pkg::SZ_W : m68k_dec_pkg::SZ_B;
                  d.src_kind = m68k_dec_pkg::K_IMM;
                  d.extension_count = 3'd1;
                  d.dst_kind = op[6] ? m68k_dec_pkg::K_SR : m68k_dec_pkg::K_CCR;
               end else begin
                  sz = m68k_dec_pkg::size_of_bits(b76);
                  d.op_size = sz;
                  ed = m68k_dec_pkg::ea_dec(sm, sr, sz);
                  ok = (sz != m68k_dec_pkg::SZ_N) && ed.ok;
                  d.src_kind = m68k_dec_pkg::K_IMM;
                  d.dst_kind = ed.kind; d.dst_register = ed.regn;
                  d.extension_count = ((sz == m68k_dec_pkg::SZ_L) ? 3'd2 : 3'd1) + ed.ext;
               end
            end
         end

         4'h1, 4'h2, 4'h3: begin
            unique case (top[1:0])
               2'd1: sz = m68k_dec_pkg::SZ_B;
               2'd2: sz = m68k_dec_pkg::SZ_L;
               default: sz = m68k_dec_pkg::SZ_W;
            endcase
            d.op_size = sz;
            es = m68k_dec_pkg::ea_dec(sm, sr, sz);
            ed = m68k_dec_pkg::ea_dec(dm, dr, sz);
            d.mnemonic = (dm == 3'd1) ? m68k_dec_pkg::M_MOVEA : m68k_dec_pkg::M_MOVE;
            ok = es.ok && ed.ok && !(dm == 3'd1 && sz == m68k_dec_pkg::SZ_B);
            d.src_kind = es.kind; d.src_register = es.regn;
            d.dst_kind = ed.kind; d.dst_register = ed.regn;
            d.extension_count = es.ext + ed.ext;
         end

         4'h4: begin
            if (b8) begin
               if (b76 == 2'd2) begin
                  d.mnemonic = m68k_dec_pkg::M_CHK; d.op_size = m68k_dec_pkg::SZ_W;
                  es = m68k_dec_pkg::ea_dec(sm, sr, m68k_dec_pkg::SZ_W);
                  d.dst_kind = m68k_dec_pkg::K_DN;
               end else begin
                  d.mnemonic = m68k_dec_pkg::M_LEA; d.op_size = m68k_dec_pkg::SZ_L;
                  es = m68k_dec_pkg::ea_dec(sm, sr, m68k_dec_pkg::SZ_L);
                  d.dst_kind = m68k_dec_pkg::K_AN;
               end
               ok = es.ok && b76[1];
               d.src_kind = es.kind; d.src_register = es.regn;
               d.dst_register = dr;
               d.extension_count = es.ext;
            end else if (sm != 3'd0 && b76[1] && dr[2] && !dr[0]) begin
               d.mnemonic = m68k_dec_pkg::M_MOVEM;
               sz = op[6] ? m68k_dec_pkg::SZ_L : m68k_dec_pkg::SZ_W;
               d.op_size = sz;
               d.register_mask = (sm == 3'd4) ? xrev : x;
               es = m68k_dec_pkg::ea_dec(sm, sr, sz);
               ok = es.ok;
               d.extension_count = 3'd1 + es.ext;
               if (dr == 3'd4) begin
                  d.src_kind = m68k_dec_pkg::K_LIST;
                  d.dst_kind = es.kind; d.dst_register = es.regn;
               end else begin
                  d.src_kind = es.kind; d.src_register = es.regn;
                  d.dst_kind = m68k_dec_pkg::K_LIST;
               end
            end else if (b76 == 2'd3) begin
               sz = (dr == 3'd5) ? m68k_dec_pkg::SZ_B :
                    (dr == 3'd7) ? m68k_dec_pkg::SZ_N : m68k_dec_pkg::SZ_W;
               es = m68k_dec_pkg::ea_dec(sm, sr, sz);
               unique case (dr)
                  3'd0, 3'd1: begin
                     d.mnemonic = m68k_dec_pkg::M_MOVE; d.op_size = m68k_dec_pkg::SZ_W;
                     d.src_kind = dr[0] ? m68k_dec_pkg::K_CCR : m68k_dec_pkg::K_SR;
                     d.dst_kind = es.kind; d.dst_register = es.regn;
                     d.extension_count = es.ext; ok = es.ok;
                  end
                  3'd2, 3'd3: begin
                     d.mnemonic = m68k_dec_pkg::M_MOVE; d.op_size = m68k_dec_pkg::SZ_W;
                     d.src_kind = es.kind; d.src_register = es.regn;
                     d.dst_kind = dr[0] ? m68k_dec_pkg::K_SR : m68k_dec_pkg::K_CCR;
                     d.extension_count = es.ext; ok = es.ok;
                  end
                  3'd4: begin
                     d.mnemonic = m68k_dec_pkg::M_EXT; d.op_size = m68k_dec_pkg::SZ_L;
                     d.src_kind = m68k_dec_pkg::K_DN; d.src_register = sr;
                  end
                  3'd5: begin
                     if (sm == 3'd7 && sr == 3'd4) begin
                        d.mnemonic = m68k_dec_pkg::M_ILLEGAL;
                     end else begin
                        d.mnemonic = m68k_dec_pkg::M_TAS; d.op_size = m68k_dec_pkg::SZ_B;
                        d.src_kind = es.kind; d.src_register = es.regn;
                        d.extension_count = es.ext; ok = es.ok;
                     end
                  end
                  3'd7: begin
                     d.mnemonic = m68k_dec_pkg::M_JMP;
                     d.src_kind = es.kind; d.src_register = es.regn;
                     d.extension_count = es.ext; ok = es.ok;
                  end
                  default: ok = 1'b0;
               endcase
            end else begin
               sz = m68k_dec_pkg::size_of_bits(b76);
               d.op_size = sz;
               es = m68k_dec_pkg::ea_dec(sm, sr, sz);
               unique case (dr)
                  3'd0, 3'd1, 3'd2, 3'd3, 3'd5: begin
                     unique case (dr)
                        3'd0: d.mnemonic = m68k_dec_pkg::M_NEGX;
                        3'd1: d.mnemonic = m68k_dec_pkg::M_CLR;
                        3'd2: d.mnemonic = m68k_dec_pkg::M_NEG;
                        3'd3: d.mnemonic = m68k_dec_pkg::M_NOT;
                        default: d.mnemonic = m68k_dec_pkg::M_TST;
                     endcase
                     d.src_kind = es.kind; d.src_register = es.regn;
                     d.extension_count = es.ext; ok = es.ok;
                  end
                  3'd4: begin
                     if (b76 == 2'd0) begin
                        d.mnemonic = m68k_dec_pkg::M_NBCD;
                        d.src_kind = es.kind; d.src_register = es.regn;
                        d.extension_count = es.ext; ok = es.ok;
                     end else if (sm == 3'd0) begin
                        d.mnemonic = (b76 == 2'd1) ? m68k_dec_pkg::M_SWAP : m68k_dec_pkg::M_EXT;
                        d.op_size = m68k_dec_pkg::SZ_W;
                        d.src_kind = m68k_dec_pkg::K_DN; d.src_register = sr;
                     end else if (b76 == 2'd1) begin
                        d.mnemonic = m68k_dec_pkg::M_PEA; d.op_size = m68k_dec_pkg::SZ_L;
                        es = m68k_dec_pkg::ea_dec(sm, sr, m68k_dec_pkg::SZ_L);
                        d.src_kind = es.kind; d.src_register = es.regn;
                        d.extension_count = es.ext; ok = es.ok;
                     end else begin
                        ok = 1'b0;
                     end
                  end
                  3'd7: begin
                     d.op_size = m68k_dec_pkg::SZ_N;
                     if (b76 == 2'd1) begin
                        unique case (sm)
                           3'd0, 3'd1: begin
                              d.mnemonic = m68k_dec_pkg::M_TRAP;
                              d.quick_value = {4'd0, op[3:0]};
                              d.src_kind = m68k_dec_pkg::K_QUICK;
                           end
                           3'd2: begin
                              d.mnemonic = m68k_dec_pkg::M_LINK;
                              d.src_kind = m68k_dec_pkg::K_AN; d.src_register = sr;
                              d.dst_kind = m68k_dec_pkg::K_IMM;
                              d.extension_count = 3'd1;
                           end
                           3'd3: begin
                              d.mnemonic = m68k_dec_pkg::M_UNLK;
                              d.src_kind = m68k_dec_pkg::K_AN; d.src_register = sr;
                           end
                           3'd4: begin
                              d.mnemonic = m68k_dec_pkg::M_MOVE; d.op_size = m68k_dec_pkg::SZ_L;
                              d.src_kind = m68k_dec_pkg::K_AN; d.src_register = sr;
                              d.dst_kind = m68k_dec_pkg::K_USP;
                           end
                           3'd5: begin
                              d.mnemonic = m68k_dec_pkg::M_MOVE; d.op_size = m68k_dec_pkg::SZ_L;
                              d.src_kind = m68k_dec_pkg::K_USP;
                              d.dst_kind = m68k_dec_pkg::K_AN; d.dst_register = sr;
                           end
                           3'd6: begin
                              d.mnemonic = m68k_dec_pkg::M_RESET + {4'd0, sr};
                              if (sr == 3'd2 || sr == 3'd4) begin
                                 d.src_kind = m68k_dec_pkg::K_IMM;
                                 d.extension_count = 3'd1;
                              end
                           end
                           default: begin
                              // Movec: only sfc, dfc, usp and vbr are known.
                              logic [1:0] idx;
                              logic [4:0] gk;
                              idx = 2'd0;
                              unique case (x[11:0])
                                 m68k_dec_pkg::CR_SFC: idx = 2'd0;
                                 m68k_dec_pkg::CR_DFC: idx = 2'd1;
                                 m68k_dec_pkg::CR_USP: idx = 2'd2;
                                 m68k_dec_pkg::CR_VBR: idx = 2'd3;
                                 default: ok = 1'b0;
                              endcase
                              gk = x[15] ? m68k_dec_pkg::K_AN : m68k_dec_pkg::K_DN;
                              d.mnemonic = m68k_dec_pkg::M_MOVEC;
                              d.op_size = m68k_dec_pkg::SZ_L;
                              d.extension_count = 3'd1;
                              if (op[0]) begin
                                 d.src_kind = gk; d.src_register = x[14:12];
                                 d.dst_kind = m68k_dec_pkg::K_CTRL;
                                 d.dst_register = {1'b0, idx};
                              end else begin
                                 d.src_kind = m68k_dec_pkg::K_CTRL;
                                 d.src_register = {1'b0, idx};
                                 d.dst_kind = gk; d.dst_register = x[14:12];
                              end
                           end
                        endcase
                     end else if (b76 == 2'd2) begin
                        d.mnemonic = m68k_dec_pkg::M_JSR;
                        es = m68k_dec_pkg::ea_dec(sm, sr, m68k_dec_pkg::SZ_N);
                        d.src_kind = es.kind; d.src_register = es.regn;
                        d.extension_count = es.ext; ok = es.ok;
                     end else begin
                        ok = 1'b0;
                     end
                  end
                  default: ok = 1'b0;
               endcase
            end
         end

         4'h5: begin
            if (b76 == 2'd3) begin
               d.condition = op[11:8];
               if (sm == 3'd1) begin
                  d.mnemonic = m68k_dec_pkg::M_DBCC; d.op_size = m68k_dec_pkg::SZ_W;
                  d.src_kind = m68k_dec_pkg::K_DN; d.src_register = sr;
                  d.dst_kind = m68k_dec_pkg::K_DISP;
                  d.extension_count = 3'd1;
               end else begin
                  d.mnemonic = m68k_dec_pkg::M_SCC; d.op_size = m68k_dec_pkg::SZ_B;
                  es = m68k_dec_pkg::ea_dec(sm, sr, m68k_dec_pkg::SZ_B);
                  d.src_kind = es.kind; d.src_register = es.regn;
                  d.extension_count = es.ext; ok = es.ok;
               end
            end else begin
               d.mnemonic = b8 ? m68k_dec_pkg::M_SUBQ : m68k_dec_pkg::M_ADDQ;
               sz = m68k_dec_pkg::size_of_bits(b76);
               d.op_size = sz;
               d.quick_value = (dr != 3'd0) ? {5'd0, dr} : 8'd8;
               d.src_kind = m68k_dec_pkg::K_QUICK;
               ed = m68k_dec_pkg::ea_dec(sm, sr, sz);
               d.dst_kind = ed.kind; d.dst_register = ed.regn;
               d.extension_count = ed.ext; ok = ed.ok;
            end
         end

         4'h6: begin
            d.mnemonic = m68k_dec_pkg::M_BCC;
            d.condition = op[11:8];
            d.src_kind = m68k_dec_pkg::K_DISP;
            if (op[7:0] == 8'd0) begin
               d.op_size = m68k_dec_pkg::SZ_W; d.extension_count = 3'd1;
            end else begin
               d.op_size = m68k_dec_pkg::SZ_B; d.quick_value = op[7:0];
            end
         end

         4'h7: begin
            ok = !b8;
            d.mnemonic = m68k_dec_pkg::M_MOVEQ; d.op_size = m68k_dec_pkg::SZ_L;
            d.quick_value = op[7:0];
            d.src_kind = m68k_dec_pkg::K_QUICK;
            d.dst_kind = m68k_dec_pkg::K_DN; d.dst_register = dr;
         end

         4'h8, 4'hc: begin
            if (top[2] && ((dm == 3'd5 && sm <= 3'd1) || (dm == 3'd6 && sm == 3'd1))) begin
               d.mnemonic = m68k_dec_pkg::M_EXG; d.op_size = m68k_dec_pkg::SZ_L;
               d.src_kind = (dm == 3'd5 && sm == 3'd1) ? m68k_dec_pkg::K_AN
                                                      : m68k_dec_pkg::K_DN;
               d.src_register = dr;
               d.dst_kind = (sm == 3'd1) ? m68k_dec_pkg::K_AN : m68k_dec_pkg::K_DN;
               d.dst_register = sr;
            end else if (dm == 3'd3 || dm == 3'd7) begin
               if (!top[2]) d.mnemonic = dm[2] ? m68k_dec_pkg::M_DIVS : m68k_dec_pkg::M_DIVU;
               else d.mnemonic = dm[2] ? m68k_dec_pkg::M_MULS : m68k_dec_pkg::M_MULU;
               d.op_size = m68k_dec_pkg::SZ_W;
               es = m68k_dec_pkg::ea_dec(sm, sr, m68k_dec_pkg::SZ_W);
               d.src_kind = es.kind; d.src_register = es.regn;
               d.dst_kind = m68k_dec_pkg::K_DN; d.dst_register = dr;
               d.extension_count = es.ext; ok = es.ok;
            end else if (dm == 3'd4 && sm[2:1] == 2'd0) begin
               d.mnemonic = top[2] ? m68k_dec_pkg::M_ABCD : m68k_dec_pkg::M_SBCD;
               d.op_size = m68k_dec_pkg::SZ_B;
               d.src_kind = op[3] ? m68k_dec_pkg::K_PRE : m68k_dec_pkg::K_DN;
               d.src_register = sr;
               d.dst_kind = op[3] ? m68k_dec_pkg::K_PRE : m68k_dec_pkg::K_DN;
               d.dst_register = dr;
            end else begin
               d.mnemonic = top[2] ? m68k_dec_pkg::M_AND : m68k_dec_pkg::M_OR;
               sz = m68k_dec_pkg::size_of_bits(b76);
               d.op_size = sz;
               es = m68k_dec_pkg::ea_dec(sm, sr, sz);
               ok = es.ok; d.extension_count = es.ext;
               if (b8) begin
                  d.src_kind = m68k_dec_pkg::K_DN; d.src_register = dr;
                  d.dst_kind = es.kind; d.dst_register = es.regn;
               end else begin
                  d.src_kind = es.kind; d.src_register = es.regn;
                  d.dst_kind = m68k_dec_pkg::K_DN; d.dst_register = dr;
               end
            end
         end

         4'h9, 4'hd, 4'hb: begin
            if (b76 == 2'd3) begin
               d.mnemonic = (top == 4'hb) ? m68k_dec_pkg::M_CMPA :
                            (top == 4'h9) ? m68k_dec_pkg::M_SUBA : m68k_dec_pkg::M_ADDA;
               sz = b8 ? m68k_dec_pkg::SZ_L : m68k_dec_pkg::SZ_W;
               d.op_size = sz;
               es = m68k_dec_pkg::ea_dec(sm, sr, sz);
               d.src_kind = es.kind; d.src_register = es.regn;
               d.dst_kind = m68k_dec_pkg::K_AN; d.dst_register = dr;
               d.extension_count = es.ext; ok = es.ok;
            end else begin
               sz = m68k_dec_pkg::size_of_bits(b76);
               d.op_size = sz;
               es = m68k_dec_pkg::ea_dec(sm, sr, sz);
               if (top != 4'hb && b8 && sm[2:1] == 2'd0) begin
                  d.mnemonic = (top == 4'h9) ? m68k_dec_pkg::M_SUBX : m68k_dec_pkg::M_ADDX;
                  d.src_kind = sm[0] ? m68k_dec_pkg::K_PRE : m68k_dec_pkg::K_DN;
                  d.src_register = sr;
                  d.dst_kind = sm[0] ? m68k_dec_pkg::K_PRE : m68k_dec_pkg::K_DN;
                  d.dst_register = dr;
               end else if (top == 4'hb && b8 && sm == 3'd1) begin
                  d.mnemonic = m68k_dec_pkg::M_CMPM;
                  d.src_kind = m68k_dec_pkg::K_POST; d.src_register = sr;
                  d.dst_kind = m68k_dec_pkg::K_POST; d.dst_register = dr;
               end else begin
                  if (top == 4'hb) d.mnemonic = b8 ? m68k_dec_pkg::M_EOR : m68k_dec_pkg::M_CMP;
                  else d.mnemonic = (top == 4'h9) ? m68k_dec_pkg::M_SUB : m68k_dec_pkg::M_ADD;
                  ok = es.ok; d.extension_count = es.ext;
                  if (b8) begin
                     d.src_kind = m68k_dec_pkg::K_DN; d.src_register = dr;
                     d.dst_kind = es.kind; d.dst_register = es.regn;
                  end else begin
                     d.src_kind = es.kind; d.src_register = es.regn;
                     d.dst_kind = m68k_dec_pkg::K_DN; d.dst_register = dr;
                  end
               end
            end
         end

         4'he: begin
            if (b76 == 2'd3) begin
               ok = !op[11];
               d.mnemonic = (b8 ? m68k_dec_pkg::M_ASL : m68k_dec_pkg::M_ASR)
                            + {5'd0, dr[1:0]};
               d.op_size = m68k_dec_pkg::SZ_W;
               es = m68k_dec_pkg::ea_dec(sm, sr, m68k_dec_pkg::SZ_W);
               d.src_kind = es.kind; d.src_register = es.regn;
               d.extension_count = es.ext;
               ok = ok && es.ok;
            end else begin
               d.mnemonic = (b8 ? m68k_dec_pkg::M_ASL : m68k_dec_pkg::M_ASR)
                            + {5'd0, sm[1:0]};
               d.op_size = m68k_dec_pkg::size_of_bits(b76);
               if (sm[2]) begin
                  d.src_kind = m68k_dec_pkg::K_DN; d.src_register = dr;
               end else begin
                  d.src_kind = m68k_dec_pkg::K_QUICK;
                  d.quick_value = (dr != 3'd0) ? {5'd0, dr} : 8'd8;
               end
               d.dst_kind = m68k_dec_pkg::K_DN; d.dst_register = sr;
            end
         end

         default: ok = 1'b0;
      endcase
      // An unknown opcode reports all zeros.
      if (!ok) d = '0;
   end

   assign word_out = d;

endmodule

// ===== sv/m68k_instruction_decoder_core.sv =====
// Top level of the 68000/68010 instruction decoder with input and result registers.
//
// Usage: drive req_word (opcode and the extension word after it) and pulse
// start. A word is taken at each clock edge where start is high and busy is
// low; busy is always low, so one word may be issued in every cycle.
// The decode of a word appears on rsp_word once it has passed the input
// register and then, through the combinational decode, the result register;
// it is marked by rsp_valid for exactly one cycle.
// Throughput is one word per cycle, set by the single pass through the
// decode logic between the two registers.
// Results cannot be held off: the receiver must take each word in the cycle
// rsp_valid is high.
// Reset (synchronous, active high) clears both valid flags, so no result
// appears until a new word is started. The block has no configuration and
// no other state.
module m68k_instruction_decoder_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  m68k_dec_pkg::req_type req_word,
   output logic                  rsp_valid,
   output m68k_dec_pkg::rsp_type rsp_word
);

   logic                  in_valid_ff, in_valid_in;
   m68k_dec_pkg::req_type in_word_ff;
   logic                  out_valid_ff, out_valid_in;
   m68k_dec_pkg::rsp_type out_word_ff, out_word_in;

   assign busy        = 1'b0;
   assign in_valid_in = start && !busy;
   assign out_valid_in = in_valid_ff;

   // Decode between the registers.
   m68k_dec_logic u_dec (
      .word_in  (in_word_ff),
      .word_out (out_word_in)
   );

   // Valid flags.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (in_valid_in) in_word_ff <= req_word;
      if (out_valid_in) out_word_ff <= out_word_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_word  = out_word_ff;

   // A taken word yields a result once it has passed both registers.
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid) else $error("result missing");
   // No result unless a word was taken into the input register beforehand.
   a_no_extra: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(in_valid_ff)) else $error("spurious result");
   // An unknown decode reports all fields zero.
   a_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.valid_res) |-> (rsp_word == '0))
      else $error("unknown opcode with nonzero fields");
   // Mask only for movem.
   a_mask: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.mnemonic != m68k_dec_pkg::M_MOVEM)
      |-> (rsp_word.register_mask == 16'd0)) else $error("stray register mask");

endmodule

// ===== tb/sv/m68k_instruction_decoder_core_test.sv =====
// Testbench for the 68000/68010 instruction decoder: directed table plus random opcode words.
module m68k_instruction_decoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   m68k_dec_pkg::req_type req_word;
   logic                  rsp_valid;
   m68k_dec_pkg::rsp_type rsp_word;

   m68k_dec_pkg::rsp_type expected_decodes[$];
   int      error_count;
   int      sender_idle_pct;

   m68k_instruction_decoder_core dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_word(req_word), .rsp_valid(rsp_valid), .rsp_word(rsp_word)
   );

   // Free-running clock, 8 ns period.
   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Place one operand in the source or destination slot.
   function automatic void put_operand(ref m68k_dec_pkg::rsp_type d, input bit to_dst,
                                       input logic [4:0] kind, input logic [2:0] rn);
      if (to_dst) begin
         d.dst_kind = kind;
         d.dst_register = rn;
      end else begin
         d.src_kind = kind;
         d.src_register = rn;
      end
   endfunction

   // Effective address operand; mode 7 with registers 5 to 7 clears valid_res.
   function automatic void put_ea(ref m68k_dec_pkg::rsp_type d, input bit to_dst,
                                  input logic [2:0] mode, input logic [2:0] rn,
                                  input logic [1:0] sz);
      if (mode != 3'd7) begin
         put_operand(d, to_dst, 5'(mode) + 5'd1, rn);
         if (mode == 3'd5 || mode == 3'd6) d.extension_count += 3'd1;
      end else begin
         case (rn)
            3'd0: begin
               put_operand(d, to_dst, m68k_dec_pkg::K_ABSW, 3'd0);
               d.extension_count += 3'd1;
            end
            3'd1: begin
               put_operand(d, to_dst, m68k_dec_pkg::K_ABSL, 3'd0);
               d.extension_count += 3'd2;
            end
            3'd2: begin
               put_operand(d, to_dst, m68k_dec_pkg::K_PCD, 3'd0);
               d.extension_count += 3'd1;
            end
            3'd3: begin
               put_operand(d, to_dst, m68k_dec_pkg::K_PCX, 3'd0);
               d.extension_count += 3'd1;
            end
            3'd4: begin
               put_operand(d, to_dst, m68k_dec_pkg::K_IMM, 3'd0);
               d.extension_count += (sz == m68k_dec_pkg::SZ_B || sz == m68k_dec_pkg::SZ_W)
                                    ? 3'd1 : 3'd2;
            end
            default: d.valid_res = 1'b0;
         endcase
      end
   endfunction

   // General register named by the top nibble of the extension word.
   function automatic void put_ext_reg(ref m68k_dec_pkg::rsp_type d, input bit to_dst,
                                       input logic [15:0] x);
      put_operand(d, to_dst, x[15] ? m68k_dec_pkg::K_AN : m68k_dec_pkg::K_DN, x[14:12]);
   endfunction

   function automatic logic [1:0] sized(input logic [1:0] b);
      return (b == 2'd0) ? m68k_dec_pkg::SZ_B : (b == 2'd1) ? m68k_dec_pkg::SZ_W :
             (b == 2'd2) ? m68k_dec_pkg::SZ_L : m68k_dec_pkg::SZ_N;
   endfunction

   // Expected decode of one opcode word and its first extension word.
   function automatic m68k_dec_pkg::rsp_type decode_opcode(input logic [15:0] op,
                                                           input logic [15:0] x);
      m68k_dec_pkg::rsp_type d;
      logic [3:0] top;
      logic [1:0] b76;
      logic [2:0] sm, sr, dm, dr;
      logic b8;
      logic [11:0] crc;
      logic [2:0] cidx;
      logic [15:0] rev;
      top = op[15:12]; b76 = op[7:6]; sm = op[5:3]; sr = op[2:0];
      dm = op[8:6]; dr = op[11:9]; b8 = op[8];
      d = '0;
      d.valid_res = 1'b1;
      case (top)
         4'h0: begin
            if (b8 || op[11:8] == 4'h8) begin
               if (sm == 3'd1) begin
                  d.mnemonic = m68k_dec_pkg::M_MOVEP;
                  d.op_size = op[6] ? m68k_dec_pkg::SZ_L : m68k_dec_pkg::SZ_W;
                  d.extension_count = 3'd1;
                  if (op[7]) begin
                     put_operand(d, 0, m68k_dec_pkg::K_DN, dr);
                     put_operand(d, 1, m68k_dec_pkg::K_D16, sr);
                  end else begin
                     put_operand(d, 0, m68k_dec_pkg::K_D16, sr);
                     put_operand(d, 1, m68k_dec_pkg::K_DN, dr);
                  end
               end else begin
                  d.mnemonic = m68k_dec_pkg::M_BTST + 7'(b76);
                  d.op_size = (sm != 0) ? m68k_dec_pkg::SZ_B : m68k_dec_pkg::SZ_L;
                  if (b8) put_operand(d, 0, m68k_dec_pkg::K_DN, dr);
                  else begin
                     put_operand(d, 0, m68k_dec_pkg::K_IMM, 3'd0); d.extension_count = 3'd1;
                  end
                  put_ea(d, 1, sm, sr, d.op_size);
               end
            end else if (dr == 3'd7) begin
               d.mnemonic = m68k_dec_pkg::M_MOVES;
               d.op_size = sized(b76);
               if (d.op_size == m68k_dec_pkg::SZ_N) d.valid_res = 1'b0;
               else begin
                  d.extension_count = 3'd1;
                  if (x[11]) begin
                     put_ext_reg(d, 0, x); put_ea(d, 1, sm, sr, d.op_size);
                  end else begin
                     put_ea(d, 0, sm, sr, d.op_size); put_ext_reg(d, 1, x);
                  end
               end
            end else begin
               case (dr)
                  3'd0: d.mnemonic = m68k_dec_pkg::M_ORI;
                  3'd1: d.mnemonic = m68k_dec_pkg::M_ANDI;
                  3'd2: d.mnemonic = m68k_dec_pkg::M_SUBI;
                  3'd3: d.mnemonic = m68k_dec_pkg::M_ADDI;
                  3'd5: d.mnemonic = m68k_dec_pkg::M_EORI;
                  3'd6: d.mnemonic = m68k_dec_pkg::M_CMPI;
                  default: d.mnemonic = m68k_dec_pkg::M_ORI;
               endcase
               if (sm == 3'd7 && sr == 3'd4) begin
                  if ((dr != 3'd0 && dr != 3'd1 && dr != 3'd5) || op[7]) d.valid_res = 1'b0;
                  else begin
                     d.op_size = op[6] ? m68k_dec_pkg::SZ_W : m68k_dec_pkg::SZ_B;
                     put_operand(d, 0, m68k_dec_pkg::K_IMM, 3'd0); d.extension_count = 3'd1;
                     put_operand(d, 1, op[6] ? m68k_dec_pkg::K_SR : m68k_dec_pkg::K_CCR, 3'd0);
                  end
               end else begin
                  d.op_size = sized(b76);
                  if (d.op_size == m68k_dec_pkg::SZ_N) d.valid_res = 1'b0;
                  else begin
                     put_ea(d, 0, 3'd7, 3'd4, d.op_size);
                     put_ea(d, 1, sm, sr, d.op_size);
                  end
               end
            end
         end
         4'h1, 4'h2, 4'h3: begin
            d.op_size = (top == 4'h1) ? m68k_dec_pkg::SZ_B :
                        (top == 4'h2) ? m68k_dec_pkg::SZ_L : m68k_dec_pkg::SZ_W;
            if (dm == 3'd1 && d.op_size == m68k_dec_pkg::SZ_B) d.valid_res = 1'b0;
            else begin
               d.mnemonic = (dm == 3'd1) ? m68k_dec_pkg::M_MOVEA : m68k_dec_pkg::M_MOVE;
               put_ea(d, 0, sm, sr, d.op_size);
               put_ea(d, 1, dm, dr, d.op_size);
            end
         end
         4'h4: begin
            if (b8) begin
               if (b76 == 2'd2) begin
                  d.mnemonic = m68k_dec_pkg::M_CHK; d.op_size = m68k_dec_pkg::SZ_W;
                  put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_W);
                  put_operand(d, 1, m68k_dec_pkg::K_DN, dr);
               end else if (b76 == 2'd3) begin
                  d.mnemonic = m68k_dec_pkg::M_LEA; d.op_size = m68k_dec_pkg::SZ_L;
                  put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_L);
                  put_operand(d, 1, m68k_dec_pkg::K_AN, dr);
               end else d.valid_res = 1'b0;
            end else if (sm != 0 && b76[1] && (dr & 3'd5) == 3'd4) begin
               d.mnemonic = m68k_dec_pkg::M_MOVEM;
               d.op_size = op[6] ? m68k_dec_pkg::SZ_L : m68k_dec_pkg::SZ_W;
               for (int i = 0; i < 16; i++) rev[i] = x[15 - i];
               d.register_mask = (sm == 3'd4) ? rev : x;
               d.extension_count = 3'd1;
               if (dr == 3'd4) begin
                  put_operand(d, 0, m68k_dec_pkg::K_LIST, 3'd0);
                  put_ea(d, 1, sm, sr, d.op_size);
               end else begin
                  put_ea(d, 0, sm, sr, d.op_size);
                  put_operand(d, 1, m68k_dec_pkg::K_LIST, 3'd0);
               end
            end else if (b76 == 2'd3) begin
               case (dr)
                  3'd0: begin
                     d.mnemonic = m68k_dec_pkg::M_MOVE; d.op_size = m68k_dec_pkg::SZ_W;
                     put_operand(d, 0, m68k_dec_pkg::K_SR, 3'd0);
                     put_ea(d, 1, sm, sr, m68k_dec_pkg::SZ_W);
                  end
                  3'd1: begin
                     d.mnemonic = m68k_dec_pkg::M_MOVE; d.op_size = m68k_dec_pkg::SZ_W;
                     put_operand(d, 0, m68k_dec_pkg::K_CCR, 3'd0);
                     put_ea(d, 1, sm, sr, m68k_dec_pkg::SZ_W);
                  end
                  3'd2: begin
                     d.mnemonic = m68k_dec_pkg::M_MOVE; d.op_size = m68k_dec_pkg::SZ_W;
                     put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_W);
                     put_operand(d, 1, m68k_dec_pkg::K_CCR, 3'd0);
                  end
                  3'd3: begin
                     d.mnemonic = m68k_dec_pkg::M_MOVE; d.op_size = m68k_dec_pkg::SZ_W;
                     put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_W);
                     put_operand(d, 1, m68k_dec_pkg::K_SR, 3'd0);
                  end
                  3'd4: begin
                     d.mnemonic = m68k_dec_pkg::M_EXT; d.op_size = m68k_dec_pkg::SZ_L;
                     put_operand(d, 0, m68k_dec_pkg::K_DN, sr);
                  end
                  3'd5: begin
                     if (sm == 3'd7 && sr == 3'd4) d.mnemonic = m68k_dec_pkg::M_ILLEGAL;
                     else begin
                        d.mnemonic = m68k_dec_pkg::M_TAS; d.op_size = m68k_dec_pkg::SZ_B;
                        put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_B);
                     end
                  end
                  3'd7: begin
                     d.mnemonic = m68k_dec_pkg::M_JMP;
                     put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_N);
                  end
                  default: d.valid_res = 1'b0;
               endcase
            end else begin
               d.op_size = sized(b76);
               case (dr)
                  3'd0: begin
                     d.mnemonic = m68k_dec_pkg::M_NEGX; put_ea(d, 0, sm, sr, d.op_size);
                  end
                  3'd1: begin
                     d.mnemonic = m68k_dec_pkg::M_CLR; put_ea(d, 0, sm, sr, d.op_size);
                  end
                  3'd2: begin
                     d.mnemonic = m68k_dec_pkg::M_NEG; put_ea(d, 0, sm, sr, d.op_size);
                  end
                  3'd3: begin
                     d.mnemonic = m68k_dec_pkg::M_NOT; put_ea(d, 0, sm, sr, d.op_size);
                  end
                  3'd5: begin
                     d.mnemonic = m68k_dec_pkg::M_TST; put_ea(d, 0, sm, sr, d.op_size);
                  end
                  3'd4: begin
                     if (b76 == 2'd0) begin
                        d.mnemonic = m68k_dec_pkg::M_NBCD;
                        put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_B);
                     end else if (sm == 3'd0) begin
                        d.mnemonic = (b76 == 2'd1) ? m68k_dec_pkg::M_SWAP
                                                   : m68k_dec_pkg::M_EXT;
                        d.op_size = m68k_dec_pkg::SZ_W;
                        put_operand(d, 0, m68k_dec_pkg::K_DN, sr);
                     end else if (b76 == 2'd1) begin
                        d.mnemonic = m68k_dec_pkg::M_PEA; d.op_size = m68k_dec_pkg::SZ_L;
                        put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_L);
                     end else d.valid_res = 1'b0;
                  end
                  3'd7: begin
                     if (b76 == 2'd1) begin
                        d.op_size = m68k_dec_pkg::SZ_N;
                        case (sm)
                           3'd0, 3'd1: begin
                              d.mnemonic = m68k_dec_pkg::M_TRAP;
                              d.quick_value = 8'(op[3:0]);
                              put_operand(d, 0, m68k_dec_pkg::K_QUICK, 3'd0);
                           end
                           3'd2: begin
                              d.mnemonic = m68k_dec_pkg::M_LINK;
                              put_operand(d, 0, m68k_dec_pkg::K_AN, sr);
                              put_operand(d, 1, m68k_dec_pkg::K_IMM, 3'd0);
                              d.extension_count = 3'd1;
                           end
                           3'd3: begin
                              d.mnemonic = m68k_dec_pkg::M_UNLK;
                              put_operand(d, 0, m68k_dec_pkg::K_AN, sr);
                           end
                           3'd4: begin
                              d.mnemonic = m68k_dec_pkg::M_MOVE;
                              d.op_size = m68k_dec_pkg::SZ_L;
                              put_operand(d, 0, m68k_dec_pkg::K_AN, sr);
                              put_operand(d, 1, m68k_dec_pkg::K_USP, 3'd0);
                           end
                           3'd5: begin
                              d.mnemonic = m68k_dec_pkg::M_MOVE;
                              d.op_size = m68k_dec_pkg::SZ_L;
                              put_operand(d, 0, m68k_dec_pkg::K_USP, 3'd0);
                              put_operand(d, 1, m68k_dec_pkg::K_AN, sr);
                           end
                           3'd6: begin
                              d.mnemonic = m68k_dec_pkg::M_RESET + 7'(sr);
                              if (sr == 3'd2 || sr == 3'd4) begin
                                 put_operand(d, 0, m68k_dec_pkg::K_IMM, 3'd0);
                                 d.extension_count = 3'd1;
                              end
                           end
                           default: begin
                              crc = x[11:0];
                              cidx = 3'd0;
                              if (crc == m68k_dec_pkg::CR_SFC) cidx = 3'd0;
                              else if (crc == m68k_dec_pkg::CR_DFC) cidx = 3'd1;
                              else if (crc == m68k_dec_pkg::CR_USP) cidx = 3'd2;
                              else if (crc == m68k_dec_pkg::CR_VBR) cidx = 3'd3;
                              else d.valid_res = 1'b0;
                              if (d.valid_res) begin
                                 d.mnemonic = m68k_dec_pkg::M_MOVEC;
                                 d.op_size = m68k_dec_pkg::SZ_L;
                                 d.extension_count = 3'd1;
                                 if (op[0]) begin
                                    put_ext_reg(d, 0, x);
                                    put_operand(d, 1, m68k_dec_pkg::K_CTRL, cidx);
                                 end else begin
                                    put_operand(d, 0, m68k_dec_pkg::K_CTRL, cidx);
                                    put_ext_reg(d, 1, x);
                                 end
                              end
                           end
                        endcase
                     end else if (b76 == 2'd2) begin
                        d.mnemonic = m68k_dec_pkg::M_JSR; d.op_size = m68k_dec_pkg::SZ_N;
                        put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_N);
                     end else d.valid_res = 1'b0;
                  end
                  default: d.valid_res = 1'b0;
               endcase
            end
         end
         4'h5: begin
            if (b76 == 2'd3) begin
               d.condition = op[11:8];
               if (sm == 3'd1) begin
                  d.mnemonic = m68k_dec_pkg::M_DBCC; d.op_size = m68k_dec_pkg::SZ_W;
                  put_operand(d, 0, m68k_dec_pkg::K_DN, sr);
                  put_operand(d, 1, m68k_dec_pkg::K_DISP, 3'd0);
                  d.extension_count = 3'd1;
               end else begin
                  d.mnemonic = m68k_dec_pkg::M_SCC; d.op_size = m68k_dec_pkg::SZ_B;
                  put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_B);
               end
            end else begin
               d.mnemonic = b8 ? m68k_dec_pkg::M_SUBQ : m68k_dec_pkg::M_ADDQ;
               d.op_size = sized(b76);
               d.quick_value = (dr != 0) ? 8'(dr) : 8'd8;
               put_operand(d, 0, m68k_dec_pkg::K_QUICK, 3'd0);
               put_ea(d, 1, sm, sr, d.op_size);
            end
         end
         4'h6: begin
            d.mnemonic = m68k_dec_pkg::M_BCC;
            d.condition = op[11:8];
            put_operand(d, 0, m68k_dec_pkg::K_DISP, 3'd0);
            if (op[7:0] == 8'd0) begin
               d.op_size = m68k_dec_pkg::SZ_W; d.extension_count = 3'd1;
            end else begin
               d.op_size = m68k_dec_pkg::SZ_B; d.quick_value = op[7:0];
            end
         end
         4'h7: begin
            if (b8) d.valid_res = 1'b0;
            else begin
               d.mnemonic = m68k_dec_pkg::M_MOVEQ; d.op_size = m68k_dec_pkg::SZ_L;
               d.quick_value = op[7:0];
               put_operand(d, 0, m68k_dec_pkg::K_QUICK, 3'd0);
               put_operand(d, 1, m68k_dec_pkg::K_DN, dr);
            end
         end
         4'h8, 4'hc: begin
            if (top == 4'hc &&
                ((dm == 3'd5 && sm <= 3'd1) || (dm == 3'd6 && sm == 3'd1))) begin
               d.mnemonic = m68k_dec_pkg::M_EXG; d.op_size = m68k_dec_pkg::SZ_L;
               put_operand(d, 0, (dm == 3'd5 && sm == 3'd1) ? m68k_dec_pkg::K_AN
                                                            : m68k_dec_pkg::K_DN, dr);
               put_operand(d, 1, (sm == 3'd1) ? m68k_dec_pkg::K_AN : m68k_dec_pkg::K_DN, sr);
            end else if (dm == 3'd3 || dm == 3'd7) begin
               if (top == 4'h8)
                  d.mnemonic = (dm == 3'd3) ? m68k_dec_pkg::M_DIVU : m68k_dec_pkg::M_DIVS;
               else
                  d.mnemonic = (dm == 3'd3) ? m68k_dec_pkg::M_MULU : m68k_dec_pkg::M_MULS;
               d.op_size = m68k_dec_pkg::SZ_W;
               put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_W);
               put_operand(d, 1, m68k_dec_pkg::K_DN, dr);
            end else if (dm == 3'd4 && sm[2:1] == 2'd0) begin
               d.mnemonic = (top == 4'h8) ? m68k_dec_pkg::M_SBCD : m68k_dec_pkg::M_ABCD;
               d.op_size = m68k_dec_pkg::SZ_B;
               put_operand(d, 0, op[3] ? m68k_dec_pkg::K_PRE : m68k_dec_pkg::K_DN, sr);
               put_operand(d, 1, op[3] ? m68k_dec_pkg::K_PRE : m68k_dec_pkg::K_DN, dr);
            end else begin
               d.mnemonic = (top == 4'h8) ? m68k_dec_pkg::M_OR : m68k_dec_pkg::M_AND;
               d.op_size = sized(b76);
               if (b8) begin
                  put_operand(d, 0, m68k_dec_pkg::K_DN, dr); put_ea(d, 1, sm, sr, d.op_size);
               end else begin
                  put_ea(d, 0, sm, sr, d.op_size); put_operand(d, 1, m68k_dec_pkg::K_DN, dr);
               end
            end
         end
         4'h9, 4'hd: begin
            if (b76 == 2'd3) begin
               d.mnemonic = (top == 4'h9) ? m68k_dec_pkg::M_SUBA : m68k_dec_pkg::M_ADDA;
               d.op_size = b8 ? m68k_dec_pkg::SZ_L : m68k_dec_pkg::SZ_W;
               put_ea(d, 0, sm, sr, d.op_size); put_operand(d, 1, m68k_dec_pkg::K_AN, dr);
            end else begin
               d.op_size = sized(b76);
               if (b8 && op[5:4] == 2'd0) begin
                  d.mnemonic = (top == 4'h9) ? m68k_dec_pkg::M_SUBX : m68k_dec_pkg::M_ADDX;
                  put_operand(d, 0, sm[0] ? m68k_dec_pkg::K_PRE : m68k_dec_pkg::K_DN, sr);
                  put_operand(d, 1, sm[0] ? m68k_dec_pkg::K_PRE : m68k_dec_pkg::K_DN, dr);
               end else begin
                  d.mnemonic = (top == 4'h9) ? m68k_dec_pkg::M_SUB : m68k_dec_pkg::M_ADD;
                  if (b8) begin
                     put_operand(d, 0, m68k_dec_pkg::K_DN, dr);
                     put_ea(d, 1, sm, sr, d.op_size);
                  end else begin
                     put_ea(d, 0, sm, sr, d.op_size);
                     put_operand(d, 1, m68k_dec_pkg::K_DN, dr);
                  end
               end
            end
         end
         4'hb: begin
            if (b76 == 2'd3) begin
               d.mnemonic = m68k_dec_pkg::M_CMPA;
               d.op_size = b8 ? m68k_dec_pkg::SZ_L : m68k_dec_pkg::SZ_W;
               put_ea(d, 0, sm, sr, d.op_size); put_operand(d, 1, m68k_dec_pkg::K_AN, dr);
            end else begin
               d.op_size = sized(b76);
               if (b8 && sm == 3'd1) begin
                  d.mnemonic = m68k_dec_pkg::M_CMPM;
                  put_operand(d, 0, m68k_dec_pkg::K_POST, sr);
                  put_operand(d, 1, m68k_dec_pkg::K_POST, dr);
               end else if (b8) begin
                  d.mnemonic = m68k_dec_pkg::M_EOR;
                  put_operand(d, 0, m68k_dec_pkg::K_DN, dr); put_ea(d, 1, sm, sr, d.op_size);
               end else begin
                  d.mnemonic = m68k_dec_pkg::M_CMP;
                  put_ea(d, 0, sm, sr, d.op_size); put_operand(d, 1, m68k_dec_pkg::K_DN, dr);
               end
            end
         end
         4'he: begin
            if (b76 == 2'd3) begin
               if (op[11]) d.valid_res = 1'b0;
               else begin
                  d.mnemonic = (b8 ? m68k_dec_pkg::M_ASL : m68k_dec_pkg::M_ASR)
                               + 7'(dr[1:0]);
                  d.op_size = m68k_dec_pkg::SZ_W;
                  put_ea(d, 0, sm, sr, m68k_dec_pkg::SZ_W);
               end
            end else begin
               d.mnemonic = (b8 ? m68k_dec_pkg::M_ASL : m68k_dec_pkg::M_ASR) + 7'(sm[1:0]);
               d.op_size = sized(b76);
               if (sm[2]) put_operand(d, 0, m68k_dec_pkg::K_DN, dr);
               else begin
                  put_operand(d, 0, m68k_dec_pkg::K_QUICK, 3'd0);
                  d.quick_value = (dr != 0) ? 8'(dr) : 8'd8;
               end
               put_operand(d, 1, m68k_dec_pkg::K_DN, sr);
            end
         end
         default: d.valid_res = 1'b0;
      endcase
      if (!d.valid_res) d = '0;
      return d;
   endfunction

   // Directed rows: opcode, extension, and a typed expectation where it is obvious.
   typedef struct {
      logic [15:0]           op;
      logic [15:0]           ext;
      bit                    typed;
      m68k_dec_pkg::rsp_type want;
   } stim_row_type;

   stim_row_type directed_rows[$];

   function automatic m68k_dec_pkg::rsp_type typed_result(input logic [6:0] mn,
                                                          input logic [1:0] sz,
                                                          input logic [4:0] sk,
                                                          input logic [4:0] dk,
                                                          input logic [2:0] ext);
      m68k_dec_pkg::rsp_type r;
      r = '0;
      r.valid_res = 1'b1; r.mnemonic = mn; r.op_size = sz;
      r.src_kind = sk; r.dst_kind = dk; r.extension_count = ext;
      return r;
   endfunction

   function automatic void add_row(input logic [15:0] op, input logic [15:0] ext,
                                   input bit typed, input m68k_dec_pkg::rsp_type want);
      stim_row_type r;
      r.op = op; r.ext = ext; r.typed = typed; r.want = want;
      directed_rows.push_back(r);
   endfunction

   // Random opcode biased toward well-formed encodings of every group.
   function automatic logic [15:0] random_opcode();
      logic [15:0] op;
      op = 16'($urandom);
      if ($urandom_range(99) < 70) begin
         // Keep effective-address fields mostly legal.
         if (op[5:3] == 3'd7 && op[2:0] > 3'd4) op[2:0] = 3'($urandom_range(4));
         if (op[15:12] inside {4'h1, 4'h2, 4'h3} && op[8:6] == 3'd7 && op[11:9] > 3'd1)
            op[11:9] = 3'($urandom_range(1));
      end
      return op;
   endfunction

   function automatic logic [15:0] random_extension(input logic [15:0] op);
      logic [15:0] x;
      x = 16'($urandom);
      if (op[15:4] == 12'h4e7 && op[3:1] == 3'b101 && $urandom_range(3) != 0) begin
         case ($urandom_range(3))
            0: x[11:0] = m68k_dec_pkg::CR_SFC;
            1: x[11:0] = m68k_dec_pkg::CR_DFC;
            2: x[11:0] = m68k_dec_pkg::CR_USP;
            default: x[11:0] = m68k_dec_pkg::CR_VBR;
         endcase
      end
      return x;
   endfunction

   // Issue one word; waits at the falling edge until it is taken.
   task automatic issue_word(input logic [15:0] op, input logic [15:0] x, input bit typed,
                             input m68k_dec_pkg::rsp_type want);
      m68k_dec_pkg::rsp_type model;
      model = decode_opcode(op, x);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_word <= '{opcode_word: op, first_extension: x};
      if (typed && want !== model)
         $display("%0t: table row %h/%h disagrees with decode: table %p, decode %p",
                  $time, op, x, want, model);
      expected_decodes.push_back(typed ? want : model);
      @(posedge clock);
      while (busy) @(posedge clock);
      @(negedge clock);
   endtask

   // Result checking at the rising edge.
   always @(posedge clock) begin
      m68k_dec_pkg::rsp_type exp_r;
      if (!reset && rsp_valid) begin
         if (expected_decodes.size() == 0) begin
            $display("%0t: unexpected decode %p", $time, rsp_word);
            error_count++;
         end else begin
            exp_r = expected_decodes.pop_front();
            if (rsp_word.valid_res !== exp_r.valid_res ||
                rsp_word.mnemonic !== exp_r.mnemonic ||
                rsp_word.condition !== exp_r.condition ||
                rsp_word.op_size !== exp_r.op_size ||
                rsp_word.src_kind !== exp_r.src_kind ||
                rsp_word.src_register !== exp_r.src_register ||
                rsp_word.dst_kind !== exp_r.dst_kind ||
                rsp_word.dst_register !== exp_r.dst_register ||
                rsp_word.extension_count !== exp_r.extension_count ||
                rsp_word.quick_value !== exp_r.quick_value ||
                rsp_word.register_mask !== exp_r.register_mask) begin
               $display("%0t: decode mismatch: expected %p, actual %p", $time, exp_r, rsp_word);
               error_count++;
            end
         end
      end
   end

   // Run limit.
   initial begin
      #2ms;
      $display("** m68k_instruction_decoder_core: FAILED **");
      $finish;
   end

   // Stimulus and end of run.
   initial begin
      logic [15:0] op;
      int wait_cycles;
      reset = 1'b1;
      start = 1'b0;
      req_word = '0;
      error_count = 0;
      sender_idle_pct = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed table: extremes, invalid forms, movem reversal, movec codes.
      add_row(16'h0000, 16'h0000, 0, '0);                  // ori.b #,d0
      add_row(16'hffff, 16'hffff, 1, '0);                  // line F is unknown
      add_row(16'hf000, 16'h0000, 1, '0);
      add_row(16'ha000, 16'h0000, 1, '0);                  // line A is unknown
      add_row(16'h4e71, 16'h0000, 1,
              typed_result(m68k_dec_pkg::M_NOP, m68k_dec_pkg::SZ_N,
                           m68k_dec_pkg::K_NONE, m68k_dec_pkg::K_NONE, 3'd0));
      add_row(16'h4e75, 16'h0000, 1,
              typed_result(m68k_dec_pkg::M_RTS, m68k_dec_pkg::SZ_N,
                           m68k_dec_pkg::K_NONE, m68k_dec_pkg::K_NONE, 3'd0));
      add_row(16'h4afc, 16'h0000, 1,
              typed_result(m68k_dec_pkg::M_ILLEGAL, m68k_dec_pkg::SZ_N,
                           m68k_dec_pkg::K_NONE, m68k_dec_pkg::K_NONE, 3'd0));
      add_row(16'h103d, 16'h0000, 1, '0);                  // mode 7 reg 5 is invalid
      add_row(16'h3047, 16'h0000, 0, '0);                  // movea.w
      add_row(16'h1047, 16'h0000, 1, '0);                  // movea.b is unknown
      add_row(16'h48a7, 16'h8001, 0, '0);                  // movem predecrement, reversed
      add_row(16'h4cdf, 16'hffff, 0, '0);                  // movem postincrement
      add_row(16'h4e7b, 16'h8801, 0, '0);                  // movec to vbr
      add_row(16'h4e7a, 16'h0802, 1, '0);                  // bad control register
      add_row(16'h003c, 16'h00ff, 0, '0);                  // ori to ccr
      add_row(16'h047c, 16'h0000, 1, '0);                  // subi to sr is unknown
      add_row(16'h06bc, 16'h0000, 0, '0);                  // addi to an immediate destination is unknown
      add_row(16'h4ebc, 16'h0000, 0, '0);                  // jsr #imm takes two words
      add_row(16'hc141, 16'h0000, 0, '0);                  // exg d0,d1
      add_row(16'hd348, 16'h0000, 0, '0);                  // addx -(a0),-(a1)
      add_row(16'he0c0, 16'h0000, 0, '0);                  // memory shift
      add_row(16'he8c0, 16'h0000, 1, '0);                  // memory shift bit 11 unknown
      add_row(16'h6000, 16'h0000, 0, '0);                  // bra word
      add_row(16'h61ff, 16'h0000, 0, '0);                  // bsr byte
      add_row(16'h0e50, 16'h0800, 0, '0);                  // moves
      foreach (directed_rows[i])
         issue_word(directed_rows[i].op, directed_rows[i].ext, directed_rows[i].typed,
                    directed_rows[i].want);

      // Random phases with different sender idling.
      for (int phase = 0; phase < 4; phase++) begin
         sender_idle_pct = (phase == 1) ? 77 : (phase == 3) ? 7 : 0;
         for (int n = 0; n < 150; n++) begin
            op = random_opcode();
            issue_word(op, random_extension(op), 0, '0);
         end
         // After the second phase, pause until every decode has come back.
         if (phase == 1) begin
            start <= 1'b0;
            while (expected_decodes.size() != 0) @(negedge clock);
         end
      end
      start <= 1'b0;

      // Drain, then wait for the last result to pass the input and result registers.
      wait_cycles = 0;
      while (expected_decodes.size() != 0 && wait_cycles < 1000) begin
         @(negedge clock);
         wait_cycles++;
      end
      repeat (4) @(negedge clock);
      if (error_count == 0 && expected_decodes.size() == 0)
         $display("** m68k_instruction_decoder_core: PASSED **");
      else
         $display("** m68k_instruction_decoder_core: FAILED **");
      $finish;
   end

endmodule
